[hw/rtl/color_matrix_with_histogram_macros.svh]
// Assertion macros shared by the colour matrix block.
`ifndef COLOR_MATRIX_WITH_HISTOGRAM_MACROS_SVH
`define COLOR_MATRIX_WITH_HISTOGRAM_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CMH_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CMH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/cmh_pkg.sv]
`default_nettype none

package cmh_pkg;

   // Field widths of the channels.
   localparam int PIX_W     = 16;
   localparam int COEF_W    = 16;
   localparam int ROW_W     = 48;
   localparam int COUNT_W   = 32;
   localparam int CH_W      = 2;
   localparam int BIN_IN_W  = 13;
   localparam int CSR_IDX_W = 2;

   // Geometry defaults.
   localparam int NUM_CH              = 3;
   localparam int BIN_SHIFT           = 3;
   localparam int HIST_BINS_DEF       = 8192;
   localparam int COEF_FRAC_BITS_DEF  = 12;

   // Register indexes on the configuration channel.
   localparam logic [CSR_IDX_W-1:0] REG_ROW_RED   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ROW_GREEN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ROW_BLUE  = 2'd2;

   // Reset values of the matrix rows: the identity matrix.
   localparam logic [ROW_W-1:0] ROW_RED_RST   = 48'h0000_0000_1000;
   localparam logic [ROW_W-1:0] ROW_GREEN_RST = 48'h0000_1000_0000;
   localparam logic [ROW_W-1:0] ROW_BLUE_RST  = 48'h1000_0000_0000;

   // Request kinds.
   localparam logic REQ_PIXEL = 1'b0;
   localparam logic REQ_READ  = 1'b1;

endpackage

`default_nettype wire

[hw/rtl/cmh_if.sv]
`default_nettype none

// Request channel: a pixel to correct or a histogram bin to read.
interface cmh_req_if;
   logic                          valid;
   logic                          ready;
   logic                          req_type;
   logic [cmh_pkg::PIX_W-1:0]     in_red;
   logic [cmh_pkg::PIX_W-1:0]     in_green;
   logic [cmh_pkg::PIX_W-1:0]     in_blue;
   logic [cmh_pkg::CH_W-1:0]      hist_channel;
   logic [cmh_pkg::BIN_IN_W-1:0]  hist_bin;
   logic                          clear_after_read;

   modport source (
      output valid, req_type, in_red, in_green, in_blue, hist_channel, hist_bin,
             clear_after_read,
      input  ready
   );
   modport sink (
      input  valid, req_type, in_red, in_green, in_blue, hist_channel, hist_bin,
             clear_after_read,
      output ready
   );
endinterface

// Response channel: corrected pixel or bin count.
interface cmh_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [cmh_pkg::PIX_W-1:0]     out_red;
   logic [cmh_pkg::PIX_W-1:0]     out_green;
   logic [cmh_pkg::PIX_W-1:0]     out_blue;
   logic [cmh_pkg::COUNT_W-1:0]   bin_count;
   logic                          is_count;

   modport source (
      output valid, out_red, out_green, out_blue, bin_count, is_count,
      input  ready
   );
   modport sink (
      input  valid, out_red, out_green, out_blue, bin_count, is_count,
      output ready
   );
endinterface

// Configuration write channel.
interface cmh_csr_if;
   logic                           valid;
   logic                           ready;
   logic [cmh_pkg::CSR_IDX_W-1:0]  index;
   logic [cmh_pkg::ROW_W-1:0]      data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[hw/rtl/color_matrix_with_histogram.sv]
// A word accepted passes the stage 1, 2 and 3 registers on to the output register.
// Throughput: one word per clock with skid slot free; histogram RMW forwards, no stall.
// A waiting result sits in the output register with a skid word behind it.
// Reset: the matrix returns to identity and the histogram is swept to zero,
// one row of all three channels per cycle, with no word accepted until the sweep ends.
`default_nettype none

`include "color_matrix_with_histogram_macros.svh"

module color_matrix_with_histogram #(
   parameter int HIST_BINS      = cmh_pkg::HIST_BINS_DEF,
   parameter int COEF_FRAC_BITS = cmh_pkg::COEF_FRAC_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   cmh_req_if.sink   req_if,
   cmh_rsp_if.source rsp_if,
   cmh_csr_if.sink   csr_if
);

   localparam int NUM_CH    = cmh_pkg::NUM_CH;
   localparam int PIX_W     = cmh_pkg::PIX_W;
   localparam int COEF_W    = cmh_pkg::COEF_W;
   localparam int ROW_W     = cmh_pkg::ROW_W;
   localparam int COUNT_W   = cmh_pkg::COUNT_W;
   localparam int CH_W      = cmh_pkg::CH_W;
   localparam int BIN_IN_W  = cmh_pkg::BIN_IN_W;
   localparam int BIN_SHIFT = cmh_pkg::BIN_SHIFT;
   localparam int BIN_W     = $clog2(HIST_BINS);
   localparam int CMP_W     = ($clog2(HIST_BINS + 1) > BIN_IN_W) ?
                              $clog2(HIST_BINS + 1) : BIN_IN_W;
   localparam int PROD_W    = COEF_W + PIX_W + 1;
   localparam int SUM_W     = PROD_W + 2;

   localparam logic [CMP_W-1:0]   BIN_LIMIT = CMP_W'(HIST_BINS);
   localparam logic [CMP_W-1:0]   BIN_LAST  = CMP_W'(HIST_BINS - 1);
   localparam logic [BIN_W-1:0]   ADDR_LAST = BIN_W'(HIST_BINS - 1);
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   typedef enum logic [1:0] {OP_NONE, OP_INC, OP_READ, OP_CLEAR} bank_op_type;

   typedef struct packed {
      logic [PIX_W-1:0]   red;
      logic [PIX_W-1:0]   green;
      logic [PIX_W-1:0]   blue;
      logic [COUNT_W-1:0] count;
      logic               is_count;
   } result_type;

   // Sign-extend a coefficient and multiply by an unsigned sample.
   function automatic logic signed [PROD_W-1:0] mul_coef(
      input logic [COEF_W-1:0] coef,
      input logic [PIX_W-1:0]  pix
   );
      logic signed [PROD_W-1:0] coef_ext;
      logic signed [PROD_W-1:0] pix_ext;
      coef_ext = PROD_W'(signed'(coef));
      pix_ext  = PROD_W'({1'b0, pix});
      return coef_ext * pix_ext;
   endfunction

   // ------------------------------------------------------------------
   // Declarations
   // ------------------------------------------------------------------
   logic [NUM_CH-1:0][ROW_W-1:0] row_ff;

   logic                     clearing_ff;
   logic [BIN_W-1:0]         clr_addr_ff;
   logic                     adv;
   logic                     req_accept;
   logic [NUM_CH-1:0][PIX_W-1:0] req_pix;

   logic                     s1_valid_ff;
   logic                     s1_is_read_ff;
   logic [CH_W-1:0]          s1_ch_ff;
   logic [BIN_IN_W-1:0]      s1_bin_ff;
   logic                     s1_clr_ff;
   logic signed [PROD_W-1:0] prod_in [NUM_CH][NUM_CH];
   logic signed [PROD_W-1:0] prod_ff [NUM_CH][NUM_CH];

   logic signed [SUM_W-1:0]  sum_w [NUM_CH];
   logic [SUM_W-1:0]         shifted_w [NUM_CH];
   logic [NUM_CH-1:0][PIX_W-1:0] pix_in;

   logic                     s2_valid_ff;
   logic                     s2_is_read_ff;
   logic [CH_W-1:0]          s2_ch_ff;
   logic [BIN_IN_W-1:0]      s2_bin_ff;
   logic                     s2_clr_ff;
   logic [NUM_CH-1:0][PIX_W-1:0] s2_pix_ff;

   logic [CMP_W-1:0]         rd_ext;
   logic                     rd_ok;
   logic [CMP_W-1:0]         pix_bin [NUM_CH];
   logic [BIN_W-1:0]         rd_addr [NUM_CH];
   bank_op_type              op_in [NUM_CH];

   logic                     s3_valid_ff;
   logic                     s3_is_read_ff;
   logic [NUM_CH-1:0][PIX_W-1:0] s3_pix_ff;
   bank_op_type              s3_op_ff [NUM_CH];
   logic [BIN_W-1:0]         s3_addr_ff [NUM_CH];
   logic [COUNT_W-1:0]       rdata_ff [NUM_CH];
   logic [NUM_CH-1:0]        fwd_hit_in;
   logic [NUM_CH-1:0]        fwd_hit_ff;
   logic [COUNT_W-1:0]       fwd_data_ff [NUM_CH];

   logic [COUNT_W-1:0]       s3_cur [NUM_CH];
   logic [COUNT_W-1:0]       s3_new [NUM_CH];
   logic [NUM_CH-1:0]        s3_we;
   logic [COUNT_W-1:0]       s3_count;
   result_type               res_in;

   logic [NUM_CH-1:0]        mem_we;
   logic [BIN_W-1:0]         mem_waddr [NUM_CH];
   logic [COUNT_W-1:0]       mem_wdata [NUM_CH];

   logic                     out_valid_ff;
   result_type               out_ff;
   logic                     skid_valid_ff;
   result_type               skid_ff;
   logic                     out_take;

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff[0] <= cmh_pkg::ROW_RED_RST;
         row_ff[1] <= cmh_pkg::ROW_GREEN_RST;
         row_ff[2] <= cmh_pkg::ROW_BLUE_RST;
      end else if (csr_if.valid) begin
         unique case (csr_if.index)
            cmh_pkg::REG_ROW_RED:   row_ff[0] <= csr_if.data;
            cmh_pkg::REG_ROW_GREEN: row_ff[1] <= csr_if.data;
            cmh_pkg::REG_ROW_BLUE:  row_ff[2] <= csr_if.data;
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Clearing sweep after reset
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clearing_ff) begin
         if (clr_addr_ff == ADDR_LAST) begin
            clearing_ff <= 1'b0;
         end else begin
            clr_addr_ff <= clr_addr_ff + BIN_W'(1);
         end
      end
   end

   // The pipeline moves as a whole while the skid slot is free.
   assign adv          = !skid_valid_ff;
   assign req_if.ready = adv && !clearing_ff;
   assign req_accept   = req_if.valid && req_if.ready;

   assign req_pix[0] = req_if.in_red;
   assign req_pix[1] = req_if.in_green;
   assign req_pix[2] = req_if.in_blue;

   // ------------------------------------------------------------------
   // Stage 1: nine coefficient products
   // ------------------------------------------------------------------
   always_comb begin
      for (int r = 0; r < NUM_CH; r++) begin
         for (int k = 0; k < NUM_CH; k++) begin
            prod_in[r][k] = mul_coef(row_ff[r][k*COEF_W +: COEF_W], req_pix[k]);
         end
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: row sums, scaling and clamp
   // ------------------------------------------------------------------
   // A negative sum scales to zero or below, so it clamps to zero and the
   // rounding direction does not matter; a positive one simply shifts.
   always_comb begin
      for (int r = 0; r < NUM_CH; r++) begin
         sum_w[r]     = SUM_W'(prod_ff[r][0]) + SUM_W'(prod_ff[r][1])
                        + SUM_W'(prod_ff[r][2]);
         shifted_w[r] = unsigned'(sum_w[r]) >> COEF_FRAC_BITS;
         if (s1_is_read_ff || sum_w[r][SUM_W-1]) begin
            pix_in[r] = '0;
         end else if (|shifted_w[r][SUM_W-1:PIX_W]) begin
            pix_in[r] = {PIX_W{1'b1}};
         end else begin
            pix_in[r] = shifted_w[r][PIX_W-1:0];
         end
      end
   end

   // ------------------------------------------------------------------
   // Bank addresses and operations, issued as memory reads from stage 2
   // ------------------------------------------------------------------
   always_comb begin
      rd_ext = CMP_W'(s2_bin_ff);
      rd_ok  = (rd_ext < BIN_LIMIT) && (s2_ch_ff < CH_W'(NUM_CH));
      for (int b = 0; b < NUM_CH; b++) begin
         pix_bin[b] = CMP_W'(s2_pix_ff[b][PIX_W-1:BIN_SHIFT]);
         if (pix_bin[b] >= BIN_LIMIT) begin
            pix_bin[b] = BIN_LAST;
         end
         if (s2_is_read_ff == cmh_pkg::REQ_READ) begin
            rd_addr[b] = rd_ext[BIN_W-1:0];
            if (rd_ok && (s2_ch_ff == CH_W'(b))) begin
               op_in[b] = s2_clr_ff ? OP_CLEAR : OP_READ;
            end else begin
               op_in[b] = OP_NONE;
            end
         end else begin
            rd_addr[b] = pix_bin[b][BIN_W-1:0];
            op_in[b]   = OP_INC;
         end
      end
   end

   // ------------------------------------------------------------------
   // Stage 3: modify and write back, with forwarding of the write that
   // lands in the same cycle as the read
   // ------------------------------------------------------------------
   always_comb begin
      s3_count = '0;
      for (int b = 0; b < NUM_CH; b++) begin
         s3_cur[b] = fwd_hit_ff[b] ? fwd_data_ff[b] : rdata_ff[b];
         unique case (s3_op_ff[b])
            OP_INC:   s3_new[b] = (s3_cur[b] == COUNT_MAX) ? s3_cur[b]
                                                            : s3_cur[b] + COUNT_W'(1);
            OP_CLEAR: s3_new[b] = '0;
            OP_READ:  s3_new[b] = s3_cur[b];
            OP_NONE:  s3_new[b] = s3_cur[b];
         endcase
         s3_we[b] = s3_valid_ff && ((s3_op_ff[b] == OP_INC) || (s3_op_ff[b] == OP_CLEAR));
         if ((s3_op_ff[b] == OP_READ) || (s3_op_ff[b] == OP_CLEAR)) begin
            s3_count = s3_cur[b];
         end
         fwd_hit_in[b] = s3_we[b] && (s3_addr_ff[b] == rd_addr[b]);
      end
   end

   assign res_in.red      = s3_pix_ff[0];
   assign res_in.green    = s3_pix_ff[1];
   assign res_in.blue     = s3_pix_ff[2];
   assign res_in.count    = s3_count;
   assign res_in.is_count = s3_is_read_ff;

   // Write port: the clearing sweep owns it after reset.
   always_comb begin
      for (int b = 0; b < NUM_CH; b++) begin
         if (clearing_ff) begin
            mem_we[b]    = 1'b1;
            mem_waddr[b] = clr_addr_ff;
            mem_wdata[b] = '0;
         end else begin
            mem_we[b]    = adv && s3_we[b];
            mem_waddr[b] = s3_addr_ff[b];
            mem_wdata[b] = s3_new[b];
         end
      end
   end

   // ------------------------------------------------------------------
   // Histogram memory: one bank per channel, read-before-write
   // ------------------------------------------------------------------
   for (genvar b = 0; b < NUM_CH; b++) begin : g_bank
      logic [COUNT_W-1:0] mem [HIST_BINS];

      always_ff @(posedge clock) begin
         if (mem_we[b]) begin
            mem[mem_waddr[b]] <= mem_wdata[b];
         end
         if (adv) begin
            rdata_ff[b] <= mem[rd_addr[b]];
         end
      end
   end

   // ------------------------------------------------------------------
   // Pipeline control
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         fwd_hit_ff  <= '0;
      end else if (adv) begin
         s1_valid_ff <= req_accept;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         fwd_hit_ff  <= fwd_hit_in;
      end
   end

   // Pipeline payload.
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_is_read_ff <= req_if.req_type;
         s1_ch_ff      <= req_if.hist_channel;
         s1_bin_ff     <= req_if.hist_bin;
         s1_clr_ff     <= req_if.clear_after_read;
         prod_ff       <= prod_in;

         s2_is_read_ff <= s1_is_read_ff;
         s2_ch_ff      <= s1_ch_ff;
         s2_bin_ff     <= s1_bin_ff;
         s2_clr_ff     <= s1_clr_ff;
         s2_pix_ff     <= pix_in;

         s3_is_read_ff <= s2_is_read_ff;
         s3_pix_ff     <= s2_pix_ff;
         s3_op_ff      <= op_in;
         s3_addr_ff    <= rd_addr;
         fwd_data_ff   <= s3_new;
      end
   end

   // ------------------------------------------------------------------
   // Output register with skid slot
   // ------------------------------------------------------------------
   assign out_take = out_valid_ff && rsp_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (out_take) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (s3_valid_ff) begin
         if (!out_valid_ff || out_take) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (out_take) begin
         out_valid_ff <= 1'b0;
      end
   end

   // Output payload follows the same choices as the valid bits above.
   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (out_take) begin
            out_ff <= skid_ff;
         end
      end else if (s3_valid_ff) begin
         if (!out_valid_ff || out_take) begin
            out_ff <= res_in;
         end else begin
            skid_ff <= res_in;
         end
      end
   end

   assign rsp_if.valid     = out_valid_ff;
   assign rsp_if.out_red   = out_ff.red;
   assign rsp_if.out_green = out_ff.green;
   assign rsp_if.out_blue  = out_ff.blue;
   assign rsp_if.bin_count = out_ff.count;
   assign rsp_if.is_count  = out_ff.is_count;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   `CMH_ASSERT_SAME(a_sweep_empty, clock, reset, clearing_ff, !(s1_valid_ff || s2_valid_ff || s3_valid_ff), "word in flight during histogram clearing sweep")
   `CMH_ASSERT_SAME(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff, "skid word held with an empty output register")
   `CMH_ASSERT_NEXT(a_result_lands, clock, reset, adv && s3_valid_ff, out_valid_ff, "finished word lost on its way to the output")
   `CMH_ASSERT_SAME(a_count_no_pixel, clock, reset, out_valid_ff && out_ff.is_count, (out_ff.red == '0) && (out_ff.green == '0) && (out_ff.blue == '0), "bin read answer carries pixel data")

endmodule

`default_nettype wire

[verif/color_matrix_with_histogram_tb.sv]
module color_matrix_with_histogram_tb;
   import cmh_pkg::*;

   // Channel codes of a bin read, and the register index that no row answers to.
   localparam logic [CH_W-1:0]      CH_RED    = 2'd0;
   localparam logic [CH_W-1:0]      CH_GREEN  = 2'd1;
   localparam logic [CH_W-1:0]      CH_BLUE   = 2'd2;
   localparam logic [CH_W-1:0]      CH_NONE   = 2'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE = 2'd3;

   localparam int CYCLE_LIMIT  = 300000;
   localparam int DRAIN_CYCLES = 8;
   localparam int LONG_HOLD    = 150;
   localparam int REPORT_LINES = 100;
   localparam int TOUCHED_KEEP = 32;

   typedef struct packed {
      logic                kind;
      logic [PIX_W-1:0]    red;
      logic [PIX_W-1:0]    green;
      logic [PIX_W-1:0]    blue;
      logic [CH_W-1:0]     channel;
      logic [BIN_IN_W-1:0] bin;
      logic                clear;
   } colour_req_t;

   typedef struct packed {
      logic [PIX_W-1:0]   red;
      logic [PIX_W-1:0]   green;
      logic [PIX_W-1:0]   blue;
      logic [COUNT_W-1:0] count;
      logic               is_count;
   } colour_rsp_t;

   // Tracks the matrix and the histogram, and holds the result words still awaited.
   class colour_scoreboard;
      logic [ROW_W-1:0]         rows [NUM_CH];
      bit [COUNT_W-1:0]         bin_counts [NUM_CH][HIST_BINS_DEF];
      colour_rsp_t              awaited [$];
      logic [CH_W+BIN_IN_W-1:0] touched [$];
      int                       errors;

      function new();
         rows[0] = ROW_RED_RST;
         rows[1] = ROW_GREEN_RST;
         rows[2] = ROW_BLUE_RST;
         errors = 0;
      endfunction

      function void set_row(logic [CSR_IDX_W-1:0] idx, logic [ROW_W-1:0] value);
         case (idx)
            REG_ROW_RED:   rows[0] = value;
            REG_ROW_GREEN: rows[1] = value;
            REG_ROW_BLUE:  rows[2] = value;
            default: ;
         endcase
      endfunction

      // Exact dot product, truncated toward zero, then clamped to the sample range.
      function logic [PIX_W-1:0] correct(logic [ROW_W-1:0] row, logic [PIX_W-1:0] r,
                                         logic [PIX_W-1:0] g, logic [PIX_W-1:0] b);
         longint sum;
         longint q;
         sum = longint'($signed(row[COEF_W-1:0])) * longint'(r)
             + longint'($signed(row[2*COEF_W-1:COEF_W])) * longint'(g)
             + longint'($signed(row[ROW_W-1:2*COEF_W])) * longint'(b);
         q = sum / (longint'(1) << COEF_FRAC_BITS_DEF);
         if (q < 0) return '0;
         if (q > 65535) return '1;
         return q[PIX_W-1:0];
      endfunction

      // Saturating bin increment; the bin is kept as a hint for later reads.
      function void bump(int ch, logic [PIX_W-1:0] value);
         int idx;
         idx = int'(value >> BIN_SHIFT);
         if (idx >= HIST_BINS_DEF) idx = HIST_BINS_DEF - 1;
         if (bin_counts[ch][idx] != '1) bin_counts[ch][idx]++;
         touched.push_back({CH_W'(ch), BIN_IN_W'(idx)});
         if (touched.size() > TOUCHED_KEEP) void'(touched.pop_front());
      endfunction

      function void note_request(colour_req_t w);
         colour_rsp_t res;
         res = '0;
         if (w.kind == REQ_PIXEL) begin
            res.red   = correct(rows[0], w.red, w.green, w.blue);
            res.green = correct(rows[1], w.red, w.green, w.blue);
            res.blue  = correct(rows[2], w.red, w.green, w.blue);
            bump(0, res.red);
            bump(1, res.green);
            bump(2, res.blue);
         end else begin
            res.is_count = 1'b1;
            if (w.channel < NUM_CH && w.bin < HIST_BINS_DEF) begin
               res.count = bin_counts[w.channel][w.bin];
               if (w.clear) bin_counts[w.channel][w.bin] = '0;
            end
         end
         awaited.push_back(res);
      endfunction

      task report(string what, logic [63:0] got, logic [63:0] want);
         errors++;
         if (errors <= REPORT_LINES)
            $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
      endtask

      task check_result(colour_rsp_t got);
         colour_rsp_t want;
         if (awaited.size() == 0) begin
            report("result word with nothing awaited", got, 0);
            return;
         end
         want = awaited.pop_front();
         if (got.red !== want.red) report("out_red", got.red, want.red);
         if (got.green !== want.green) report("out_green", got.green, want.green);
         if (got.blue !== want.blue) report("out_blue", got.blue, want.blue);
         if (got.count !== want.count) report("bin_count", got.count, want.count);
         if (got.is_count !== want.is_count)
            report("is_count", got.is_count, want.is_count);
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;
   int   cycle_count = 0;
   int   hold_asks = 0;
   logic [PIX_W-1:0] palette [8];
   colour_scoreboard board;

   cmh_req_if req_if ();
   cmh_rsp_if rsp_if ();
   cmh_csr_if csr_if ();

   color_matrix_with_histogram DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Give up if the run hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("color_matrix_with_histogram_tb failed");
         $finish;
      end
   end

   // Every result word taken is compared with the oldest awaited one.
   always @(posedge clock) begin
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
         board.check_result({rsp_if.out_red, rsp_if.out_green, rsp_if.out_blue,
                             rsp_if.bin_count, rsp_if.is_count});
   end

   // The receiver stalls on a rotating mask, now and then all ready, and holds off
   // for a long stretch whenever the stimulus asks for it.
   initial begin : receiver
      logic [15:0] mask;
      int          step;
      int          hold_left;
      int          holds_done;
      mask = '1;
      step = 0;
      hold_left = 0;
      holds_done = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_asks != holds_done) begin
            holds_done = hold_asks;
            hold_left = LONG_HOLD;
         end
         if (step % 97 == 0)
            mask = ($urandom_range(0, 2) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0101);
         step++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= mask[step % 16];
         end
      end
   end

   // Offers one word and returns at the edge where it is taken; valid stays high.
   task automatic push_word(input colour_req_t w);
      req_if.valid            <= 1'b1;
      req_if.req_type         <= w.kind;
      req_if.in_red           <= w.red;
      req_if.in_green         <= w.green;
      req_if.in_blue          <= w.blue;
      req_if.hist_channel     <= w.channel;
      req_if.hist_bin         <= w.bin;
      req_if.clear_after_read <= w.clear;
      @(posedge clock);
      while (req_if.ready !== 1'b1) @(posedge clock);
      board.note_request(w);
   endtask

   task automatic push_csr(input logic [CSR_IDX_W-1:0] idx, input logic [ROW_W-1:0] value);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      @(posedge clock);
      while (csr_if.ready !== 1'b1) @(posedge clock);
      board.set_row(idx, value);
   endtask

   task automatic load_matrix(input logic [ROW_W-1:0] r, input logic [ROW_W-1:0] g,
                              input logic [ROW_W-1:0] b);
      push_csr(REG_ROW_RED, r);
      push_csr(REG_ROW_GREEN, g);
      push_csr(REG_ROW_BLUE, b);
      csr_if.valid <= 1'b0;
   endtask

   task automatic wait_idle();
      while (board.awaited.size() != 0) @(posedge clock);
   endtask

   function automatic colour_req_t pixel_word(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g,
                                              logic [PIX_W-1:0] b);
      colour_req_t w;
      w = '0;
      w.kind = REQ_PIXEL;
      w.red = r;
      w.green = g;
      w.blue = b;
      return w;
   endfunction

   function automatic colour_req_t read_word(logic [CH_W-1:0] ch, logic [BIN_IN_W-1:0] bin,
                                             logic clr);
      colour_req_t w;
      w = '0;
      w.kind = REQ_READ;
      w.channel = ch;
      w.bin = bin;
      w.clear = clr;
      return w;
   endfunction

   // Half of the pixels come from a small palette so that bins fill and neighbouring
   // words hit the same bin; reads mostly target bins that were recently bumped.
   function automatic colour_req_t random_word();
      colour_req_t              w;
      logic [CH_W+BIN_IN_W-1:0] spot;
      int                       pick;
      w.kind    = ($urandom_range(0, 3) == 0) ? REQ_READ : REQ_PIXEL;
      w.red     = 16'($urandom);
      w.green   = 16'($urandom);
      w.blue    = 16'($urandom);
      w.channel = 2'($urandom);
      w.bin     = 13'($urandom);
      w.clear   = 1'($urandom);
      if (w.kind == REQ_PIXEL) begin
         pick = $urandom_range(0, 3);
         if (pick == 1) begin
            w.red   = $urandom_range(0, 1) ? '1 : '0;
            w.green = $urandom_range(0, 1) ? '1 : '0;
            w.blue  = $urandom_range(0, 1) ? '1 : '0;
         end else if (pick >= 2) begin
            w.red   = palette[$urandom_range(0, 7)];
            w.green = palette[$urandom_range(0, 7)];
            w.blue  = palette[$urandom_range(0, 7)];
         end
      end else begin
         if (board.touched.size() != 0 && $urandom_range(0, 9) < 7) begin
            spot = board.touched[$urandom_range(0, board.touched.size() - 1)];
            w.channel = spot[CH_W+BIN_IN_W-1:BIN_IN_W];
            w.bin = spot[BIN_IN_W-1:0];
         end else begin
            w.channel = CH_W'($urandom_range(0, 2));
         end
         if ($urandom_range(0, 9) == 0) w.channel = CH_NONE;
         w.clear = ($urandom_range(0, 2) == 0);
      end
      return w;
   endfunction

   // Bursts of random length; a gap only lowers valid when it really idles.
   task automatic run_random(input int count);
      int sent;
      int burst;
      int gap;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 24);
         while (burst > 0 && sent < count) begin
            push_word(random_word());
            burst--;
            sent++;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_if.valid <= 1'b0;
   endtask

   task automatic run_phase(input logic [ROW_W-1:0] r, input logic [ROW_W-1:0] g,
                            input logic [ROW_W-1:0] b, input int count, input bit squeeze);
      load_matrix(r, g, b);
      foreach (palette[i]) palette[i] = 16'($urandom);
      if (squeeze) hold_asks++;
      run_random(count);
      wait_idle();
   endtask

   // Extremes, every request kind, the unused channel code, clears and
   // back-to-back hits on one bin, all under the identity matrix.
   task automatic run_directed();
      colour_req_t w;
      push_word(pixel_word(16'h0000, 16'h0000, 16'h0000));
      push_word(pixel_word(16'hFFFF, 16'hFFFF, 16'hFFFF));
      push_word(pixel_word(16'h0007, 16'h0008, 16'hFFF8));
      push_word(read_word(CH_RED, 13'd0, 1'b0));
      push_word(read_word(CH_RED, 13'd0, 1'b1));
      push_word(read_word(CH_RED, 13'd0, 1'b0));
      push_word(read_word(CH_GREEN, 13'd8191, 1'b0));
      push_word(read_word(CH_NONE, 13'd0, 1'b1));
      push_word(read_word(CH_BLUE, 13'd0, 1'b0));
      repeat (3) push_word(pixel_word(16'd100, 16'd100, 16'd100));
      push_word(read_word(CH_RED, 13'd12, 1'b1));
      push_word(pixel_word(16'd100, 16'd100, 16'd100));
      push_word(read_word(CH_RED, 13'd12, 1'b0));
      // Fields of the other request kind must be ignored.
      w = pixel_word(16'h1234, 16'h8000, 16'h7FFF);
      w.channel = CH_NONE;
      w.bin = '1;
      w.clear = 1'b1;
      push_word(w);
      w = read_word(CH_BLUE, 13'd8191, 1'b1);
      w.red = '1;
      w.green = '1;
      w.blue = '1;
      push_word(w);
      push_word(read_word(CH_BLUE, 13'd8191, 1'b0));
      push_word(read_word(CH_GREEN, 13'd12, 1'b0));
      push_word(read_word(CH_NONE, 13'd8191, 1'b0));
      req_if.valid <= 1'b0;
   endtask

   initial begin : stimulus
      board = new();
      reset <= 1'b1;
      req_if.valid            <= 1'b0;
      req_if.req_type         <= REQ_PIXEL;
      req_if.in_red           <= '0;
      req_if.in_green         <= '0;
      req_if.in_blue          <= '0;
      req_if.hist_channel     <= CH_RED;
      req_if.hist_bin         <= '0;
      req_if.clear_after_read <= 1'b0;
      csr_if.valid            <= 1'b0;
      csr_if.index            <= REG_ROW_RED;
      csr_if.data             <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      run_directed();
      wait_idle();

      // A write to the spare index must leave the matrix alone.
      push_csr(REG_SPARE, 48'hFFFF_FFFF_FFFF);
      run_phase('0, '0, '0, 60, 1'b0);
      run_phase({3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}}, 60, 1'b0);
      run_phase({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}}, 60, 1'b0);
      run_phase({3{16'hFFFF}}, {3{16'hFFFF}}, {3{16'hFFFF}}, 60, 1'b0);
      // Typical correction with negative cross terms; the receiver holds off here.
      run_phase(48'hFCCD_FB33_1800, 48'hFD71_1666_FC29, 48'hEF5C_FE14_2000, 100, 1'b1);
      run_phase(48'h0000_0800_0800, 48'h0555_0555_0555, 48'h1000_0000_1000, 80, 1'b0);
      run_phase({16'($urandom), 32'($urandom)}, {16'($urandom), 32'($urandom)},
                {16'($urandom), 32'($urandom)}, 80, 1'b0);

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.awaited.size() != 0)
         board.report("result words never returned", board.awaited.size(), 0);
      if (board.errors == 0)
         $display("color_matrix_with_histogram_tb passed");
      else
         $display("color_matrix_with_histogram_tb failed");
      $finish;
   end

endmodule
